@@ hdl/ctk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctk_pkg
// Shared types and codes of the three-mode character tokenizer.
// ---------------------------------------------------------------------------
package ctk_pkg;

   // input word
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   // result word
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [31:0] value;
      logic [63:0] text;
      logic [6:0]  text_len;
      logic        overflow;
      logic        last;
   } rsp_type;

   // token under construction
   typedef struct packed {
      logic [2:0]  pend;
      logic [63:0] text;
      logic [6:0]  cnt;
      logic [31:0] acc;
      logic        ovf;
      logic        plus;
   } tok_state_type;

   // mode and the constant limit's split by ten, from the register block
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] quot;
      logic [3:0]  rem;
   } ctk_cfg_type;

   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_URL     = 2'd1;
   localparam logic [1:0] MODE_HTML    = 2'd2;

   localparam logic [2:0] PEND_NONE    = 3'd0;
   localparam logic [2:0] PEND_IDENT   = 3'd1;
   localparam logic [2:0] PEND_INT     = 3'd2;
   localparam logic [2:0] PEND_URLDIG  = 3'd3;
   localparam logic [2:0] PEND_URLWORD = 3'd4;
   localparam logic [2:0] PEND_TAG     = 3'd5;
   localparam logic [2:0] PEND_HTMLWD  = 3'd6;

   localparam logic [4:0] TOK_IDENT     = 5'd0;
   localparam logic [4:0] TOK_INT       = 5'd1;
   localparam logic [4:0] TOK_PERIOD    = 5'd2;
   localparam logic [4:0] TOK_SEMI      = 5'd3;
   localparam logic [4:0] TOK_QUOTE     = 5'd4;
   localparam logic [4:0] TOK_SYMBOL    = 5'd5;
   localparam logic [4:0] TOK_URLDIGITS = 5'd6;
   localparam logic [4:0] TOK_HTTP      = 5'd7;
   localparam logic [4:0] TOK_URLWORD   = 5'd8;
   localparam logic [4:0] TOK_URLWORDP  = 5'd9;
   localparam logic [4:0] TOK_COLON     = 5'd10;
   localparam logic [4:0] TOK_SLASH     = 5'd11;
   localparam logic [4:0] TOK_DOT       = 5'd12;
   localparam logic [4:0] TOK_URLOTHER  = 5'd13;
   localparam logic [4:0] TOK_TAGOPEN   = 5'd14;
   localparam logic [4:0] TOK_CLOSETAG  = 5'd15;
   localparam logic [4:0] TOK_TAGCLOSE  = 5'd16;
   localparam logic [4:0] TOK_HTMLWORD  = 5'd17;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam logic [63:0] PACK_HTTP  = 64'h0000_0000_7074_7468;
   localparam logic [63:0] PACK_HTTPS = 64'h0000_0073_7074_7468;

   // register indexes
   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   localparam logic [31:0] LIMIT_RESET = 32'd2147483647;
   localparam logic [31:0] QUOT_RESET  = 32'd214748364;
   // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage
`default_nettype wire

@@ hdl/three_mode_char_tokenizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// three_mode_char_tokenizer_core
// Character tokenizer with default, URL and HTML modes.
// ---------------------------------------------------------------------------
// One character word enters per cycle while the queue has room. It is
// registered in the input register, then the token logic updates the
// pending token and writes its zero, one or two result words into a
// four-entry result queue whose head is the output, so a result word passes
// the input register and a queue entry before it can be accepted. The input
// side keeps taking a word every cycle as long as the queue has two free
// entries; a long run of characters that each give two tokens is paced by
// the result side at one word per cycle while the receiver is ready. A
// register write takes effect for the next character the token logic steps.
// ---------------------------------------------------------------------------
module three_mode_char_tokenizer_core
   import ctk_pkg::*;
#(
   parameter int MAX_WORD_LEN = 8,
   parameter int MAX_URL_LEN  = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   ctk_cfg_type   cfg;
   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_data_ff;
   tok_state_type st_ff;
   tok_state_type st_in;
   rsp_type       res_a;
   rsp_type       res_b;
   logic [1:0]    res_n;
   logic [1:0]    push_n;
   logic          room;
   logic          step_go;

   assign csr_pready = 1'b1;

   ctk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign step_go     = in_valid_ff & room;
   assign req_ready   = ~in_valid_ff | step_go;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~step_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) in_data_ff <= req_data;
   end

   ctk_step #(
      .MAX_WORD_LEN (MAX_WORD_LEN),
      .MAX_URL_LEN  (MAX_URL_LEN)
   ) u_step (
      .ch     (in_data_ff.ch),
      .eoi    (in_data_ff.end_of_input),
      .cfg    (cfg),
      .st_in  (st_ff),
      .st_out (st_in),
      .res_a  (res_a),
      .res_b  (res_b),
      .res_n  (res_n)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step_go) begin
         st_ff <= st_in;
      end
   end

   assign push_n = step_go ? res_n : 2'd0;

   ctk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (res_a),
      .push_b    (res_b),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ hdl/ctk_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctk_csr
// Mode and constant-limit registers behind a simple bus port; also keeps
// the limit split into quotient and remainder by ten.
// ---------------------------------------------------------------------------
module ctk_csr
   import ctk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      ctk_cfg_type cfg
);

   logic [1:0]  mode_ff;
   logic [31:0] limit_ff;
   logic [31:0] quot_ff;
   logic [63:0] prod;
   logic [3:0]  ten_quot_lo;
   logic        wr_en;
   logic        reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DEFAULT;
         limit_ff <= LIMIT_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_MODE:  mode_ff  <= csr_pwdata[1:0];
            REG_LIMIT: limit_ff <= csr_pwdata;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   // limit / 10 by reciprocal multiply, loaded at the same edge as the limit
   assign prod = {32'd0, csr_pwdata} * {32'd0, RECIP_TEN};

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff <= QUOT_RESET;
      end else if (wr_en && reg_sel == REG_LIMIT) begin
         quot_ff <= {3'd0, prod[63:35]};
      end
   end

   // remainder fits in four bits, so only the low bits of 10*q matter
   assign ten_quot_lo = {quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0};

   assign cfg.mode = mode_ff;
   assign cfg.quot = quot_ff;
   assign cfg.rem  = limit_ff[3:0] - ten_quot_lo;

   always_comb begin
      case (reg_sel)
         REG_MODE:  csr_prdata = {30'd0, mode_ff};
         REG_LIMIT: csr_prdata = limit_ff;
         default:   csr_prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/ctk_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctk_step
// Per-character logic: updates the pending token and forms up to two
// result words (the finished token, then the character's own token).
// ---------------------------------------------------------------------------
module ctk_step
   import ctk_pkg::*;
#(
   parameter int MAX_WORD_LEN = 8,
   parameter int MAX_URL_LEN  = 64
)
(
   input  wire logic          [7:0] ch,
   input  wire logic                eoi,
   input  wire ctk_cfg_type         cfg,
   input  wire tok_state_type       st_in,
   output      tok_state_type       st_out,
   output      rsp_type             res_a,
   output      rsp_type             res_b,
   output      logic          [1:0] res_n
);

   localparam logic [6:0] WORD_BOUND = 7'(MAX_WORD_LEN);
   localparam logic [6:0] URL_BOUND  = 7'(MAX_URL_LEN);

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      to_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic tok_state_type put_char(input tok_state_type s, input logic [7:0] c,
                                              input logic [6:0] bound);
      tok_state_type o;
      o = s;
      if (s.cnt < bound) begin
         for (int i = 0; i < 8; i++) begin
            if (s.cnt == 7'(i)) o.text[8*i +: 8] = c;
         end
         o.cnt = s.cnt + 7'd1;
      end else begin
         o.ovf = 1'b1;
      end
      put_char = o;
   endfunction

   function automatic tok_state_type add_digit(input tok_state_type s, input logic [7:0] c,
                                               input logic [31:0] q, input logic [3:0] r);
      tok_state_type o;
      logic [3:0]    d;
      o = s;
      d = c[3:0];
      if (s.acc < q || (s.acc == q && d <= r)) begin
         o.acc = (s.acc << 3) + (s.acc << 1) + {28'd0, d};
      end else begin
         o.ovf = 1'b1;
      end
      add_digit = o;
   endfunction

   function automatic rsp_type mk_tok(input logic [4:0] kind, input logic [31:0] value,
                                      input logic [63:0] text, input logic [6:0] len,
                                      input logic ovf);
      rsp_type t;
      t.token_kind = kind;
      t.value      = value;
      t.text       = text;
      t.text_len   = len;
      t.overflow   = ovf;
      t.last       = 1'b0;
      mk_tok = t;
   endfunction

   tok_state_type cleared;
   tok_state_type absorb_st;
   tok_state_type start_st;
   tok_state_type slash_st;
   rsp_type       pend_tok;
   rsp_type       start_tok;
   logic          has_pend;
   logic          absorbed;
   logic          start_emit;
   logic          is_http;
   logic          is_alnum;
   rsp_type       a_w;
   rsp_type       b_w;
   logic [1:0]    n_w;

   assign cleared  = '0;
   assign has_pend = st_in.pend != PEND_NONE;
   assign is_alnum = is_alpha(ch) || is_digit(ch);
   assign is_http  = !st_in.ovf && ((st_in.cnt == 7'd4 && st_in.text == PACK_HTTP) ||
                                    (st_in.cnt == 7'd5 && st_in.text == PACK_HTTPS));
   assign slash_st = put_char(st_in, ch, URL_BOUND);

   // the token that is pending now, as it would leave
   always_comb begin
      case (st_in.pend)
         PEND_IDENT:   pend_tok = mk_tok(TOK_IDENT, 32'd0, st_in.text, st_in.cnt, st_in.ovf);
         PEND_INT:     pend_tok = mk_tok(TOK_INT, st_in.acc, 64'd0, 7'd0, st_in.ovf);
         PEND_URLDIG:  pend_tok = mk_tok(TOK_URLDIGITS, st_in.acc, 64'd0, 7'd0, st_in.ovf);
         PEND_URLWORD: pend_tok = mk_tok(is_http ? TOK_HTTP :
                                         (st_in.plus ? TOK_URLWORDP : TOK_URLWORD),
                                         32'd0, st_in.text, st_in.cnt, st_in.ovf);
         PEND_TAG:     pend_tok = mk_tok(TOK_TAGOPEN, 32'd0, st_in.text, st_in.cnt, 1'b0);
         PEND_HTMLWD:  pend_tok = mk_tok(TOK_HTMLWORD, 32'd0, st_in.text, st_in.cnt, st_in.ovf);
         default:      pend_tok = '0;
      endcase
   end

   // does the character continue the pending token
   always_comb begin
      absorbed  = 1'b0;
      absorb_st = st_in;
      case (st_in.pend)
         PEND_IDENT: begin
            absorbed  = is_alnum;
            absorb_st = put_char(st_in, to_upper(ch), WORD_BOUND);
         end
         PEND_INT, PEND_URLDIG: begin
            absorbed  = is_digit(ch);
            absorb_st = add_digit(st_in, ch, cfg.quot, cfg.rem);
         end
         PEND_URLWORD: begin
            absorbed       = is_alnum || ch == CH_PLUS;
            absorb_st      = put_char(st_in, ch, URL_BOUND);
            absorb_st.plus = st_in.plus || ch == CH_PLUS;
         end
         PEND_HTMLWD: begin
            absorbed  = is_alnum;
            absorb_st = put_char(st_in, ch, URL_BOUND);
         end
         default: begin
            absorbed  = 1'b0;
            absorb_st = st_in;
         end
      endcase
   end

   // what the character starts from a clear state
   always_comb begin
      start_st   = cleared;
      start_emit = 1'b0;
      start_tok  = '0;
      case (cfg.mode)
         MODE_DEFAULT: begin
            if (is_alpha(ch)) begin
               start_st      = put_char(cleared, to_upper(ch), WORD_BOUND);
               start_st.pend = PEND_IDENT;
            end else if (is_digit(ch)) begin
               start_st      = add_digit(cleared, ch, cfg.quot, cfg.rem);
               start_st.pend = PEND_INT;
            end else begin
               start_emit = 1'b1;
               if (ch == CH_DOT) begin
                  start_tok = mk_tok(TOK_PERIOD, 32'd0, 64'd0, 7'd0, 1'b0);
               end else if (ch == CH_SEMI) begin
                  start_tok = mk_tok(TOK_SEMI, 32'd0, 64'd0, 7'd0, 1'b0);
               end else if (ch == CH_QUOTE) begin
                  start_tok = mk_tok(TOK_QUOTE, 32'd0, 64'd0, 7'd0, 1'b0);
               end else begin
                  start_tok = mk_tok(TOK_SYMBOL, {24'd0, ch}, 64'd0, 7'd0, 1'b0);
               end
            end
         end
         MODE_URL: begin
            if (is_digit(ch)) begin
               start_st      = add_digit(cleared, ch, cfg.quot, cfg.rem);
               start_st.pend = PEND_URLDIG;
            end else if (is_alpha(ch)) begin
               start_st      = put_char(cleared, ch, URL_BOUND);
               start_st.pend = PEND_URLWORD;
            end else begin
               start_emit = 1'b1;
               if (ch == CH_COLON) begin
                  start_tok = mk_tok(TOK_COLON, 32'd0, 64'd0, 7'd0, 1'b0);
               end else if (ch == CH_SLASH) begin
                  start_tok = mk_tok(TOK_SLASH, 32'd0, 64'd0, 7'd0, 1'b0);
               end else if (ch == CH_DOT) begin
                  start_tok = mk_tok(TOK_DOT, 32'd0, 64'd0, 7'd0, 1'b0);
               end else begin
                  start_tok = mk_tok(TOK_URLOTHER, 32'd0, 64'd0, 7'd0, 1'b0);
               end
            end
         end
         MODE_HTML: begin
            if (ch == CH_LT) begin
               start_st      = put_char(cleared, ch, URL_BOUND);
               start_st.pend = PEND_TAG;
            end else if (ch == CH_GT) begin
               start_emit = 1'b1;
               start_tok  = mk_tok(TOK_TAGCLOSE, 32'd0, 64'd0, 7'd0, 1'b0);
            end else begin
               start_st      = put_char(cleared, ch, URL_BOUND);
               start_st.pend = PEND_HTMLWD;
            end
         end
         default: begin
            start_st   = cleared;
            start_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      st_out = st_in;
      a_w    = '0;
      b_w    = '0;
      n_w    = 2'd0;
      if (eoi) begin
         st_out = cleared;
         if (has_pend) begin
            a_w = pend_tok;
            n_w = 2'd1;
         end
      end else if (ch != 8'd0) begin
         if (st_in.pend == PEND_TAG && ch == CH_SLASH) begin
            a_w    = mk_tok(TOK_CLOSETAG, 32'd0, slash_st.text, slash_st.cnt, 1'b0);
            n_w    = 2'd1;
            st_out = cleared;
         end else if (absorbed) begin
            st_out = absorb_st;
         end else begin
            st_out = start_st;
            if (has_pend) begin
               a_w = pend_tok;
               b_w = start_tok;
               n_w = start_emit ? 2'd2 : 2'd1;
            end else if (start_emit) begin
               a_w = start_tok;
               n_w = 2'd1;
            end
         end
      end
      case (n_w)
         2'd1:    a_w.last = 1'b1;
         2'd2:    b_w.last = 1'b1;
         default: a_w.last = 1'b0;
      endcase
   end

   assign res_a = a_w;
   assign res_b = b_w;
   assign res_n = n_w;

endmodule
`default_nettype wire

@@ hdl/ctk_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctk_queue
// Small result queue: takes up to two words per cycle, hands out one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module ctk_queue
   import ctk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] push_n,
   input  wire rsp_type    push_a,
   input  wire rsp_type    push_b,
   output      logic       room,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data
);

   rsp_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wp_ff;
   logic [QPTR_W-1:0]   wp_in;
   logic [QPTR_W-1:0]   wp_next;
   logic [QPTR_W-1:0]   rp_ff;
   logic [QPTR_W-1:0]   rp_in;
   logic [QCNT_W-1:0]   cnt_ff;
   logic [QCNT_W-1:0]   cnt_in;
   logic                pop;

   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = entry_ff[rp_ff];
   // two free slots so an item's pair of words always fits
   assign room      = cnt_ff <= QCNT_W'(QDEPTH - 2);
   assign wp_next   = wp_ff + QPTR_W'(1);

   assign wp_in  = wp_ff + QPTR_W'(push_n);
   assign rp_in  = rp_ff + QPTR_W'(pop);
   assign cnt_in = cnt_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) entry_ff[wp_ff] <= push_a;
      if (push_n == 2'd2) entry_ff[wp_next] <= push_b;
   end

endmodule
`default_nettype wire

@@ tb/sv/three_mode_char_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_mode_char_tokenizer_core_tb
// Self-checking bench for the three-mode character tokenizer.
// A token scoreboard tracks its own pending token and register copies,
// predicts the token words of every accepted character word and compares
// them field by field with the result channel. A directed run through the
// three modes is followed by random token-shaped streams under a range of
// mode and constant-limit settings and three back-pressure profiles.
// ---------------------------------------------------------------------------
module three_mode_char_tokenizer_core_tb;
   import ctk_pkg::*;

   localparam int WORD_BOUND = 8;
   localparam int URL_BOUND  = 64;

   class token_scoreboard;
      logic [1:0]  mode;
      logic [31:0] limit;
      logic [2:0]  pend;
      logic [63:0] text;
      int unsigned cnt;
      logic [31:0] acc;
      bit          ovf;
      bit          plus;
      rsp_type     expected_tokens[$];
      rsp_type     fresh[$];
      int          errors;

      function new();
         mode   = MODE_DEFAULT;
         limit  = LIMIT_RESET;
         errors = 0;
         clear_token();
      endfunction

      function void write_reg(logic idx, logic [31:0] v);
         if (idx == REG_MODE) mode = v[1:0];
         else limit = v;
      endfunction

      function void clear_token();
         pend = PEND_NONE;
         text = '0;
         cnt  = 0;
         acc  = '0;
         ovf  = 1'b0;
         plus = 1'b0;
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic [7:0] upcase(logic [7:0] c);
         return (c >= "a" && c <= "z") ? c - 8'd32 : c;
      endfunction

      function void put_char(logic [7:0] c, int unsigned bound);
         if (cnt < bound) begin
            if (cnt < 8) text[8*cnt +: 8] = c;
            cnt++;
         end else begin
            ovf = 1'b1;
         end
      endfunction

      function void add_digit(logic [7:0] c);
         logic [31:0] d, quo, rm;
         d   = {24'd0, c - 8'h30};
         quo = limit / 10;
         rm  = limit % 10;
         if (acc < quo || (acc == quo && d <= rm)) acc = acc * 10 + d;
         else ovf = 1'b1;
      endfunction

      function void push(logic [4:0] kind, logic [31:0] value, logic [63:0] txt,
                         int unsigned len, bit o);
         rsp_type r;
         r.token_kind = kind;
         r.value      = value;
         r.text       = txt;
         r.text_len   = len[6:0];
         r.overflow   = o;
         r.last       = 1'b0;
         fresh.push_back(r);
      endfunction

      function void flush_pending();
         logic [4:0] kind;
         case (pend)
            PEND_IDENT: push(TOK_IDENT, '0, text, cnt, ovf);
            PEND_INT, PEND_URLDIG: begin
               push(pend == PEND_INT ? TOK_INT : TOK_URLDIGITS, acc, '0, 0, ovf);
            end
            PEND_URLWORD: begin
               if (!ovf && ((cnt == 4 && text == PACK_HTTP) ||
                            (cnt == 5 && text == PACK_HTTPS)))
                  kind = TOK_HTTP;
               else
                  kind = plus ? TOK_URLWORDP : TOK_URLWORD;
               push(kind, '0, text, cnt, ovf);
            end
            PEND_TAG:    push(TOK_TAGOPEN, '0, text, cnt, 1'b0);
            PEND_HTMLWD: push(TOK_HTMLWORD, '0, text, cnt, ovf);
            default: ;
         endcase
         clear_token();
      endfunction

      // true when the character extends the pending token
      function bit absorb(logic [7:0] c);
         case (pend)
            PEND_IDENT: begin
               if (!(is_alpha(c) || is_digit(c))) return 1'b0;
               put_char(upcase(c), WORD_BOUND);
               return 1'b1;
            end
            PEND_INT, PEND_URLDIG: begin
               if (!is_digit(c)) return 1'b0;
               add_digit(c);
               return 1'b1;
            end
            PEND_URLWORD: begin
               if (!(is_alpha(c) || is_digit(c)) && c != CH_PLUS) return 1'b0;
               if (c == CH_PLUS) plus = 1'b1;
               put_char(c, URL_BOUND);
               return 1'b1;
            end
            PEND_HTMLWD: begin
               if (!(is_alpha(c) || is_digit(c))) return 1'b0;
               put_char(c, URL_BOUND);
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void start(logic [7:0] c);
         if (mode == MODE_DEFAULT) begin
            if (is_alpha(c)) begin
               pend = PEND_IDENT;
               put_char(upcase(c), WORD_BOUND);
            end else if (is_digit(c)) begin
               pend = PEND_INT;
               add_digit(c);
            end else if (c == CH_DOT) push(TOK_PERIOD, '0, '0, 0, 1'b0);
            else if (c == CH_SEMI) push(TOK_SEMI, '0, '0, 0, 1'b0);
            else if (c == CH_QUOTE) push(TOK_QUOTE, '0, '0, 0, 1'b0);
            else push(TOK_SYMBOL, {24'd0, c}, '0, 0, 1'b0);
         end else if (mode == MODE_URL) begin
            if (is_digit(c)) begin
               pend = PEND_URLDIG;
               add_digit(c);
            end else if (is_alpha(c)) begin
               pend = PEND_URLWORD;
               put_char(c, URL_BOUND);
            end else if (c == CH_COLON) push(TOK_COLON, '0, '0, 0, 1'b0);
            else if (c == CH_SLASH) push(TOK_SLASH, '0, '0, 0, 1'b0);
            else if (c == CH_DOT) push(TOK_DOT, '0, '0, 0, 1'b0);
            else push(TOK_URLOTHER, '0, '0, 0, 1'b0);
         end else if (mode == MODE_HTML) begin
            if (c == CH_LT) begin
               pend = PEND_TAG;
               put_char(c, URL_BOUND);
            end else if (c == CH_GT) begin
               push(TOK_TAGCLOSE, '0, '0, 0, 1'b0);
            end else begin
               pend = PEND_HTMLWD;
               put_char(c, URL_BOUND);
            end
         end
      endfunction

      function void note_word(req_type w);
         fresh.delete();
         if (w.end_of_input) begin
            flush_pending();
         end else if (w.ch != 8'h00) begin
            if (pend == PEND_TAG && w.ch == CH_SLASH) begin
               put_char(w.ch, URL_BOUND);
               push(TOK_CLOSETAG, '0, text, cnt, 1'b0);
               clear_token();
            end else if (!absorb(w.ch)) begin
               flush_pending();
               start(w.ch);
            end
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            $error("token word with none expected: kind %0d text %0h",
                   got.token_kind, got.text);
            errors++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.token_kind, got.token_kind);
         compare_field("value", want.value, got.value);
         compare_field("text", want.text, got.text);
         compare_field("text_len", want.text_len, got.text_len);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   token_scoreboard board = new();
   int unsigned send_idle = 16;
   int unsigned recv_idle = 57;
   int unsigned words_sent = 0;

   three_mode_char_tokenizer_core #(
      .MAX_WORD_LEN(WORD_BOUND),
      .MAX_URL_LEN (URL_BOUND)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_token(rsp_data);
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_word(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{ch: c, end_of_input: eoi};
      do @(posedge clock); while (!req_ready);
      board.note_word('{ch: c, end_of_input: eoi});
      if (eoi || c != 8'h00) words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // wait for every predicted token, then for words that gave none
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // limit split by ten is registered
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_letter();
      logic [7:0] c;
      c = 8'h41 + $urandom_range(25);
      if ($urandom_range(1)) c = c + 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'h30 + $urandom_range(9);
   endfunction

   function automatic logic [7:0] pick_alnum();
      int unsigned r;
      r = $urandom_range(61);
      if (r < 26) return 8'h41 + r;
      else if (r < 52) return 8'h61 + r - 26;
      else return 8'h30 + r - 52;
   endfunction

   // rest of a word after its first character
   task automatic send_tail(input int unsigned n, input bit plus_ok);
      for (int unsigned i = 1; i < n; i++) begin
         if (plus_ok && $urandom_range(7) == 0) send_word(CH_PLUS, 1'b0);
         else send_word(pick_alnum(), 1'b0);
      end
   endtask

   function automatic int unsigned word_len();
      return ($urandom_range(29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
   endfunction

   task automatic send_chunk(input logic [1:0] m);
      int unsigned pick;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_word($urandom_range(255), 1'b0);
      end else if (pick < 13) begin
         send_word($urandom_range(255), 1'b1);
      end else if (m == MODE_DEFAULT) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            send_word(pick_letter(), 1'b0);
            send_tail($urandom_range(1, 11), 1'b0);
         end else if (pick < 7) begin
            repeat ($urandom_range(1, 12)) send_word(pick_digit(), 1'b0);
         end else if (pick == 7) begin
            send_word(" ", 1'b0);
         end else begin
            case ($urandom_range(3))
               0: send_word(CH_DOT, 1'b0);
               1: send_word(CH_SEMI, 1'b0);
               2: send_word(CH_QUOTE, 1'b0);
               default: send_word($urandom_range(33, 126), 1'b0);
            endcase
         end
      end else if (m == MODE_URL) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            if ($urandom_range(1)) send_text("https");
            else send_text("http");
            if ($urandom_range(3) == 0) send_word(pick_alnum(), 1'b0);
            if ($urandom_range(1)) send_text("://");
         end else if (pick < 6) begin
            send_word(pick_letter(), 1'b0);
            send_tail(word_len(), 1'b1);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 12)) send_word(pick_digit(), 1'b0);
         end else begin
            case ($urandom_range(3))
               0: send_word(CH_COLON, 1'b0);
               1: send_word(CH_SLASH, 1'b0);
               2: send_word(CH_DOT, 1'b0);
               default: send_word($urandom_range(1, 255), 1'b0);
            endcase
         end
      end else if (m == MODE_HTML) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            send_word(CH_LT, 1'b0);
            if ($urandom_range(1)) send_word(CH_SLASH, 1'b0);
            send_word(pick_letter(), 1'b0);
            send_tail($urandom_range(1, 8), 1'b0);
            send_word(CH_GT, 1'b0);
         end else if (pick < 7) begin
            do c = $urandom_range(1, 255); while (c == CH_LT || c == CH_GT);
            send_word(c, 1'b0);
            send_tail(word_len(), 1'b0);
         end else begin
            case ($urandom_range(2))
               0: send_word(CH_LT, 1'b0);
               1: send_word(CH_GT, 1'b0);
               default: send_word($urandom_range(1, 255), 1'b0);
            endcase
         end
      end else begin
         send_word($urandom_range(255), 1'b0);
      end
   endtask

   logic [1:0]  phase_mode  [12] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1,
                                     2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3};
   logic [31:0] phase_limit [12] = '{LIMIT_RESET, 32'd10, 32'hFFFF_FFFF, 32'd0,
                                     32'd9, 32'd0, 32'd99999, 32'd9,
                                     32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0};
   bit          phase_rand  [12] = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 1};

   initial begin
      int unsigned budget;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default mode: ident ended by period, flushed constant, lone tokens
      send_text("ab1.");
      send_word("7", 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'h00, 1'b1);
      send_word(CH_SEMI, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      settle();
      write_reg(REG_MODE, {30'd0, MODE_URL});
      send_text("9x+:");
      send_text("http/");
      settle();
      write_reg(REG_MODE, {30'd0, MODE_HTML});
      send_text("</a><b");
      send_word(8'h00, 1'b1);
      settle();

      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin
            send_idle = 57;
            recv_idle = 16;
         end else if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_reg(REG_MODE, {30'd0, phase_mode[p]});
         write_reg(REG_LIMIT, phase_rand[p] ? $urandom() : phase_limit[p]);
         budget = words_sent + ((phase_mode[p] == 2'd3) ? 40 : 180);
         while (words_sent < budget) send_chunk(phase_mode[p]);
         settle();
      end
      send_word(8'h00, 1'b1);
      settle();

      if (board.errors == 0) begin
         $display("[three_mode_char_tokenizer_core] OK");
      end else begin
         $display("[three_mode_char_tokenizer_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[three_mode_char_tokenizer_core] ERROR");
      $finish;
   end

endmodule
